// ===== src/mta_pkg.sv =====
// Shared types, field layout constants and saturating helpers for the
// mesh tangent unit. No dependencies.
package mta_pkg;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [47:0] sum_type;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_TRI  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam logic [1:0] REQ_NOP  = 2'd3;

   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 112;
   localparam int ATTR_W     = 256;
   localparam int SUMS_W     = 144;

   localparam sum_type MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam sum_type MIN48 = 48'sh8000_0000_0000;
   localparam logic [30:0] ONE30 = 31'h4000_0000;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   function automatic q16_type sat_delta(input q16_type b, input q16_type a);
      logic signed [32:0] d;
      d = $signed({b[31], b}) - $signed({a[31], a});
      if (d > 33'sh0_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (d < -33'sh0_7FFF_FFFF) begin
         return 32'sh8000_0001;
      end
      return d[31:0];
   endfunction

   function automatic sum_type sat_add48(input sum_type s, input sum_type v);
      logic signed [48:0] r;
      r = $signed({s[47], s}) + $signed({v[47], v});
      if (r[48] != r[47]) begin
         return r[48] ? MIN48 : MAX48;
      end
      return r[47:0];
   endfunction

endpackage

// ===== src/mesh_tangent_accumulate_orthonormalize_top.sv =====
// Per-vertex tangent unit: vertex and tangent-sum memories, a shared multiplier, block
// scaling, a square root and a three-lane bit-serial divider. Depends on mta_pkg.
// A load or a no-op goes straight to the result beat; a triangle runs the multiply sequence and
// the 80-step divider (not when degenerate), and a read runs one-bit block scaling, the square
// root and the divider (not for a zero sum).
// One request is in work at a time; reset clears the control state only.
module mesh_tangent_accumulate_orthonormalize_top
   import mta_pkg::*;
#(
   parameter int VERTEX_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z,
   // corner_b, corner_c, two zero bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // echo_index, tangent_x, tangent_y, tangent_z, six zero bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]            rsp_tuser
);

   localparam int IDX_W = $clog2(VERTEX_DEPTH);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_R_ISSUE   = 5'd1;
   localparam logic [4:0] ST_R_LATCH   = 5'd2;
   localparam logic [4:0] ST_SCALE_T   = 5'd3;
   localparam logic [4:0] ST_DOT       = 5'd4;
   localparam logic [4:0] ST_DD        = 5'd5;
   localparam logic [4:0] ST_NDD       = 5'd6;
   localparam logic [4:0] ST_SCALE_W   = 5'd7;
   localparam logic [4:0] ST_SQ        = 5'd8;
   localparam logic [4:0] ST_SQRT      = 5'd9;
   localparam logic [4:0] ST_R_DIVLD   = 5'd10;
   localparam logic [4:0] ST_DIV       = 5'd11;
   localparam logic [4:0] ST_R_FIN     = 5'd12;
   localparam logic [4:0] ST_T_ISSUE_A = 5'd13;
   localparam logic [4:0] ST_T_ISSUE_B = 5'd14;
   localparam logic [4:0] ST_T_ISSUE_C = 5'd15;
   localparam logic [4:0] ST_T_DELTA   = 5'd16;
   localparam logic [4:0] ST_T_MUL     = 5'd17;
   localparam logic [4:0] ST_T_DET     = 5'd18;
   localparam logic [4:0] ST_T_TERM    = 5'd19;
   localparam logic [4:0] ST_T_SRD     = 5'd20;
   localparam logic [4:0] ST_T_SWR     = 5'd21;
   localparam logic [4:0] ST_DONE      = 5'd22;

   function automatic logic [IDX_W-1:0] reduce_idx(input logic [9:0] raw);
      logic [16:0] v;
      v = {7'd0, raw};
      for (int k = 9; k >= 0; k--) begin
         if ((VERTEX_DEPTH << k) <= 1023) begin
            if (v >= 17'(VERTEX_DEPTH << k)) begin
               v = v - 17'(VERTEX_DEPTH << k);
            end
         end
      end
      return v[IDX_W-1:0];
   endfunction

   logic [4:0]             state_ff, state_in;
   logic [6:0]             cnt_ff;
   logic [1:0]             ccnt_ff;
   logic [1:0]             rtype_ff;
   logic [IDX_W-1:0]       a_ff, b_ff, c_ff;

   logic [ATTR_W-1:0]      attr_mem [VERTEX_DEPTH];
   logic [ATTR_W-1:0]      attr_rd_ff;
   logic [IDX_W-1:0]       attr_raddr, attr_waddr;
   logic                   attr_we;
   logic [SUMS_W-1:0]      sum_mem [VERTEX_DEPTH];
   logic [SUMS_W-1:0]      sum_rd_ff, sum_wdata;
   logic [IDX_W-1:0]       sum_raddr, sum_waddr, corner_addr;
   logic                   sum_we;

   logic [159:0]           va_ff, vb_ff;
   q16_type                dlt_ff [10];
   q16_type                nrm_ff [3];
   logic [47:0]            mag_ff [3];
   logic                   sgn_ff [3];
   logic signed [63:0]     acc_ff [4];
   logic signed [63:0]     prod_ff;
   q16_type                mul_a, mul_b;
   q16_type                dd_ff;
   q16_type                lane_s [3];

   logic [61:0]            sq_src_ff;
   logic [33:0]            sq_rem_ff;
   logic [30:0]            sq_root_ff;
   logic [33:0]            sq_sh, sq_trial;

   logic [79:0]            num_ff [3];
   logic [63:0]            rem_ff [3];
   logic [46:0]            quo_ff [3];
   logic                   ovf_ff [3];
   logic                   neg_ff [3];
   logic [63:0]            div_d_ff;
   logic [63:0]            div_sh [3];
   sum_type                term_ff [3];

   logic [9:0]             echo_ff;
   q16_type                tan_ff [3];
   logic                   deg_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;
   logic [0:0]             rsp_tuser_ff;

   logic                   req_fire, out_free;
   logic [47:0]            or_m;
   logic                   scale_zero, scale_hi, scale_lo;
   logic [1:0]             pidx;
   logic [63:0]            dot_mag, pmag, det_mag;
   logic [30:0]            dd_clamp;
   logic signed [48:0]     t49, s49;
   logic signed [49:0]     w50;
   logic [49:0]            wmag;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign pidx       = cnt_ff[2:1];

   assign or_m       = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign scale_zero = (or_m == 48'd0);
   assign scale_hi   = |or_m[47:30];
   assign scale_lo   = !or_m[29];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_s[k] = sgn_ff[k] ? -$signed({2'b00, mag_ff[k][29:0]})
                               : $signed({2'b00, mag_ff[k][29:0]});
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_T_MUL: begin
            case (cnt_ff[3:1])
               3'd0:    begin mul_a = dlt_ff[6]; mul_b = dlt_ff[9]; end
               3'd1:    begin mul_a = dlt_ff[8]; mul_b = dlt_ff[7]; end
               3'd2:    begin mul_a = dlt_ff[9]; mul_b = dlt_ff[0]; end
               3'd3:    begin mul_a = dlt_ff[7]; mul_b = dlt_ff[3]; end
               3'd4:    begin mul_a = dlt_ff[9]; mul_b = dlt_ff[1]; end
               3'd5:    begin mul_a = dlt_ff[7]; mul_b = dlt_ff[4]; end
               3'd6:    begin mul_a = dlt_ff[9]; mul_b = dlt_ff[2]; end
               default: begin mul_a = dlt_ff[7]; mul_b = dlt_ff[5]; end
            endcase
         end
         ST_DOT: begin
            mul_a = nrm_ff[pidx];
            mul_b = lane_s[pidx];
         end
         ST_NDD: begin
            mul_a = nrm_ff[pidx];
            mul_b = dd_ff;
         end
         ST_SQ: begin
            mul_a = lane_s[pidx];
            mul_b = lane_s[pidx];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      dot_mag  = acc_ff[0][63] ? 64'(-acc_ff[0]) : 64'(acc_ff[0]);
      det_mag  = dot_mag;
      dd_clamp = (dot_mag[63:16] > {17'd0, MAX31}) ? MAX31 : dot_mag[46:16];
      pmag     = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      t49      = sgn_ff[pidx] ? -$signed({1'b0, mag_ff[pidx]}) : $signed({1'b0, mag_ff[pidx]});
      s49      = prod_ff[63] ? -$signed({1'b0, pmag[63:16]}) : $signed({1'b0, pmag[63:16]});
      w50      = $signed({t49[48], t49}) - $signed({s49[48], s49});
      wmag     = w50[49] ? 50'(-w50) : 50'(w50);
      sq_sh    = {sq_rem_ff[31:0], sq_src_ff[61:60]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
      for (int k = 0; k < 3; k++) begin
         div_sh[k] = {rem_ff[k][62:0], num_ff[k][79]};
      end
   end

   always_comb begin
      case (ccnt_ff)
         2'd0:    corner_addr = a_ff;
         2'd1:    corner_addr = b_ff;
         default: corner_addr = c_ff;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_T_ISSUE_B: attr_raddr = b_ff;
         ST_T_ISSUE_C: attr_raddr = c_ff;
         default:      attr_raddr = a_ff;
      endcase
      sum_raddr  = (state_ff == ST_T_SRD) ? corner_addr : a_ff;
      attr_waddr = reduce_idx(req_tdata[9:0]);
      attr_we    = req_fire && (req_tuser == REQ_LOAD);
      sum_we     = attr_we || (state_ff == ST_T_SWR);
      sum_waddr  = attr_we ? attr_waddr : corner_addr;
      if (attr_we) begin
         sum_wdata = '0;
      end else begin
         sum_wdata = {sat_add48(sum_rd_ff[143:96], term_ff[2]),
                      sat_add48(sum_rd_ff[95:48], term_ff[1]),
                      sat_add48(sum_rd_ff[47:0], term_ff[0])};
      end
   end

   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_waddr] <= req_tdata[265:10];
      end
      attr_rd_ff <= attr_mem[attr_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_TRI:  state_in = ST_T_ISSUE_A;
                  REQ_READ: state_in = ST_R_ISSUE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_R_ISSUE: state_in = ST_R_LATCH;
         ST_R_LATCH: state_in = ST_SCALE_T;
         ST_SCALE_T: begin
            if (scale_zero) begin
               state_in = ST_DONE;
            end else if (!scale_hi && !scale_lo) begin
               state_in = ST_DOT;
            end
         end
         ST_DOT:     if (cnt_ff == 7'd5) state_in = ST_DD;
         ST_DD:      state_in = ST_NDD;
         ST_NDD:     if (cnt_ff == 7'd5) state_in = ST_SCALE_W;
         ST_SCALE_W: begin
            if (scale_zero) begin
               state_in = ST_DONE;
            end else if (!scale_hi && !scale_lo) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ:      if (cnt_ff == 7'd5) state_in = ST_SQRT;
         ST_SQRT:    if (cnt_ff == 7'd31) state_in = ST_R_DIVLD;
         ST_R_DIVLD: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 7'd79) begin
               state_in = (rtype_ff == REQ_READ) ? ST_R_FIN : ST_T_TERM;
            end
         end
         ST_R_FIN:     state_in = ST_DONE;
         ST_T_ISSUE_A: state_in = ST_T_ISSUE_B;
         ST_T_ISSUE_B: state_in = ST_T_ISSUE_C;
         ST_T_ISSUE_C: state_in = ST_T_DELTA;
         ST_T_DELTA:   state_in = ST_T_MUL;
         ST_T_MUL:     if (cnt_ff == 7'd15) state_in = ST_T_DET;
         ST_T_DET:     state_in = (acc_ff[0] == 64'sd0) ? ST_DONE : ST_DIV;
         ST_T_TERM:    state_in = ST_T_SRD;
         ST_T_SRD:     state_in = ST_T_SWR;
         ST_T_SWR:     state_in = (ccnt_ff == 2'd2) ? ST_DONE : ST_T_SRD;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= (state_in != state_ff) ? 7'd0 : cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      case (state_ff)
         ST_IDLE: begin
            rtype_ff <= req_tuser;
            a_ff     <= reduce_idx(req_tdata[9:0]);
            b_ff     <= reduce_idx(req_tdata[275:266]);
            c_ff     <= reduce_idx(req_tdata[285:276]);
            echo_ff  <= req_tdata[9:0];
            deg_ff   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
               tan_ff[k] <= '0;
            end
         end
         ST_R_LATCH: begin
            for (int k = 0; k < 3; k++) begin
               sgn_ff[k] <= sum_rd_ff[48*k+47];
               mag_ff[k] <= sum_rd_ff[48*k+47] ? 48'(-sum_rd_ff[48*k +: 48])
                                               : sum_rd_ff[48*k +: 48];
               nrm_ff[k] <= attr_rd_ff[160+32*k +: 32];
            end
         end
         ST_SCALE_T, ST_SCALE_W: begin
            for (int k = 0; k < 3; k++) begin
               if (!scale_zero && scale_hi) begin
                  mag_ff[k] <= {1'b0, mag_ff[k][47:1]};
               end else if (!scale_zero && scale_lo) begin
                  mag_ff[k] <= {mag_ff[k][46:0], 1'b0};
               end
            end
         end
         ST_DOT, ST_SQ: begin
            if (cnt_ff[0]) begin
               acc_ff[0] <= ((pidx == 2'd0) ? 64'sd0 : acc_ff[0]) + prod_ff;
            end
         end
         ST_DD: begin
            dd_ff <= acc_ff[0][63] ? -$signed({1'b0, dd_clamp}) : $signed({1'b0, dd_clamp});
         end
         ST_NDD: begin
            if (cnt_ff[0]) begin
               mag_ff[pidx] <= wmag[47:0];
               sgn_ff[pidx] <= w50[49];
            end
         end
         ST_SQRT: begin
            if (cnt_ff == 7'd0) begin
               sq_src_ff  <= acc_ff[0][61:0];
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
            end else begin
               sq_src_ff <= {sq_src_ff[59:0], 2'b00};
               if (sq_sh >= sq_trial) begin
                  sq_rem_ff  <= sq_sh - sq_trial;
                  sq_root_ff <= {sq_root_ff[29:0], 1'b1};
               end else begin
                  sq_rem_ff  <= sq_sh;
                  sq_root_ff <= {sq_root_ff[29:0], 1'b0};
               end
            end
         end
         ST_R_DIVLD: begin
            div_d_ff <= {33'd0, sq_root_ff};
            for (int k = 0; k < 3; k++) begin
               num_ff[k] <= {20'd0, mag_ff[k][29:0], 30'd0};
               rem_ff[k] <= '0;
               quo_ff[k] <= '0;
               ovf_ff[k] <= 1'b0;
               neg_ff[k] <= sgn_ff[k];
            end
         end
         ST_DIV: begin
            for (int k = 0; k < 3; k++) begin
               num_ff[k] <= {num_ff[k][78:0], 1'b0};
               ovf_ff[k] <= ovf_ff[k] | quo_ff[k][46];
               if (div_sh[k] >= div_d_ff) begin
                  rem_ff[k] <= div_sh[k] - div_d_ff;
                  quo_ff[k] <= {quo_ff[k][45:0], 1'b1};
               end else begin
                  rem_ff[k] <= div_sh[k];
                  quo_ff[k] <= {quo_ff[k][45:0], 1'b0};
               end
            end
         end
         ST_R_FIN: begin
            for (int k = 0; k < 3; k++) begin
               if (quo_ff[k] > {16'd0, ONE30}) begin
                  tan_ff[k] <= neg_ff[k] ? -$signed({1'b0, ONE30}) : $signed({1'b0, ONE30});
               end else begin
                  tan_ff[k] <= neg_ff[k] ? -$signed({1'b0, quo_ff[k][30:0]})
                                         : $signed({1'b0, quo_ff[k][30:0]});
               end
            end
         end
         ST_T_ISSUE_B: va_ff <= attr_rd_ff[159:0];
         ST_T_ISSUE_C: vb_ff <= attr_rd_ff[159:0];
         ST_T_DELTA: begin
            for (int k = 0; k < 3; k++) begin
               dlt_ff[k]   <= sat_delta(vb_ff[32*k +: 32], va_ff[32*k +: 32]);
               dlt_ff[k+3] <= sat_delta(attr_rd_ff[32*k +: 32], va_ff[32*k +: 32]);
            end
            dlt_ff[6] <= sat_delta(vb_ff[127:96], va_ff[127:96]);
            dlt_ff[7] <= sat_delta(vb_ff[159:128], va_ff[159:128]);
            dlt_ff[8] <= sat_delta(attr_rd_ff[127:96], va_ff[127:96]);
            dlt_ff[9] <= sat_delta(attr_rd_ff[159:128], va_ff[159:128]);
            for (int k = 0; k < 4; k++) begin
               acc_ff[k] <= '0;
            end
         end
         ST_T_MUL: begin
            if (cnt_ff[0]) begin
               if (cnt_ff[1]) begin
                  acc_ff[cnt_ff[3:2]] <= acc_ff[cnt_ff[3:2]] - prod_ff;
               end else begin
                  acc_ff[cnt_ff[3:2]] <= acc_ff[cnt_ff[3:2]] + prod_ff;
               end
            end
         end
         ST_T_DET: begin
            deg_ff   <= (acc_ff[0] == 64'sd0);
            div_d_ff <= det_mag;
            for (int k = 0; k < 3; k++) begin
               num_ff[k] <= {(acc_ff[k+1][63] ? 64'(-acc_ff[k+1]) : 64'(acc_ff[k+1])), 16'd0};
               rem_ff[k] <= '0;
               quo_ff[k] <= '0;
               ovf_ff[k] <= 1'b0;
               neg_ff[k] <= acc_ff[k+1][63] ^ acc_ff[0][63];
            end
         end
         ST_T_TERM: begin
            ccnt_ff <= 2'd0;
            for (int k = 0; k < 3; k++) begin
               if (ovf_ff[k]) begin
                  term_ff[k] <= neg_ff[k] ? MIN48 : MAX48;
               end else begin
                  term_ff[k] <= neg_ff[k] ? -$signed({1'b0, quo_ff[k]}) : $signed({1'b0, quo_ff[k]});
               end
            end
         end
         ST_T_SWR: ccnt_ff <= ccnt_ff + 2'd1;
         ST_DONE: begin
            if (out_free) begin
               rsp_tdata_ff <= {6'd0, tan_ff[2], tan_ff[1], tan_ff[0], echo_ff};
               rsp_tuser_ff <= deg_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== test/tb_mesh_tangent_accumulate_orthonormalize_top.sv =====
// Testbench for the per-vertex tangent unit: directed and random load, triangle,
// read and no-op beats checked against a fixed-point predictor in a scoreboard.
// Depends on mta_pkg and mesh_tangent_accumulate_orthonormalize_top.
`timescale 1ns / 1ps

module tb_mesh_tangent_accumulate_orthonormalize_top;
   import mta_pkg::*;

   localparam int DEPTH = 1024;
   localparam longint LIM31 = 64'sd2147483647;
   localparam longint LIM48 = 64'sd140737488355327;
   localparam longint UNIT30 = 64'sd1073741824;
   localparam int WATCH_LIMIT = 5000;

   typedef struct {
      logic [1:0]  kind;
      logic [9:0]  idx;
      logic [31:0] f[8];
      logic [9:0]  cb;
      logic [9:0]  cc;
   } mesh_req_type;

   typedef struct {
      logic [9:0]  idx;
      logic [31:0] t[3];
      logic        degen;
   } tangent_rsp_type;

   class tangent_scoreboard_type;
      longint           attr[8][DEPTH];
      longint           tsum[3][DEPTH];
      tangent_rsp_type  pending[$];
      int               errors = 0;

      function longint unsigned mag(longint v);
         return v < 0 ? longint'(0) - v : v;
      endfunction

      function longint shr_tz(longint v, int k);
         longint unsigned m;
         m = mag(v) >> k;
         return v < 0 ? -longint'(m) : longint'(m);
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint quot16(longint num, longint den);
         bit neg;
         longint unsigned n, d, q, r;
         neg = (num < 0) != (den < 0);
         n = mag(num);
         d = mag(den);
         q = n / d;
         r = n % d;
         if (q >= 64'd2147483648) return neg ? -LIM48 - 1 : LIM48;
         for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
               r = r - d;
               q = q | 1;
            end
         end
         return clip(neg ? -longint'(q) : longint'(q), -LIM48 - 1, LIM48);
      endfunction

      function bit normalize_range(inout longint v[3]);
         longint unsigned m;
         int k;
         m = mag(v[0]);
         k = 0;
         if (mag(v[1]) > m) m = mag(v[1]);
         if (mag(v[2]) > m) m = mag(v[2]);
         if (m == 0) return 0;
         if (m >= UNIT30) begin
            while ((m >> k) >= UNIT30) k++;
            for (int i = 0; i < 3; i++) v[i] = shr_tz(v[i], k);
         end else begin
            while ((m << k) < (UNIT30 >> 1)) k++;
            for (int i = 0; i < 3; i++) v[i] = v[i] * (longint'(1) << k);
         end
         return 1;
      endfunction

      function longint unsigned root(longint unsigned x);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function void orthonormal_tangent(int a, output longint o[3]);
         longint t[3], w[3], dt, dd;
         longint unsigned ss, len, q;
         o = '{0, 0, 0};
         for (int k = 0; k < 3; k++) t[k] = tsum[k][a];
         if (!normalize_range(t)) return;
         dt = attr[5][a] * t[0] + attr[6][a] * t[1] + attr[7][a] * t[2];
         dd = clip(shr_tz(dt, 16), -LIM31, LIM31);
         for (int k = 0; k < 3; k++) w[k] = t[k] - shr_tz(attr[5 + k][a] * dd, 16);
         if (!normalize_range(w)) return;
         ss = 0;
         for (int k = 0; k < 3; k++) ss += mag(w[k]) * mag(w[k]);
         len = root(ss);
         for (int k = 0; k < 3; k++) begin
            q = (mag(w[k]) << 30) / len;
            if (q > UNIT30) q = UNIT30;
            o[k] = w[k] < 0 ? -longint'(q) : longint'(q);
         end
      endfunction

      function longint dlt(int f, int b, int a);
         return clip(attr[f][b] - attr[f][a], -LIM31, LIM31);
      endfunction

      function void note_request(mesh_req_type r);
         tangent_rsp_type e;
         longint o[3], e1[3], e2[3], s1, t1, s2, t2, det, tv;
         int a, b, c;
         a = int'(r.idx);
         e.idx = r.idx;
         e.t = '{0, 0, 0};
         e.degen = 0;
         case (r.kind)
            REQ_LOAD: begin
               for (int i = 0; i < 8; i++) attr[i][a] = longint'(signed'(r.f[i]));
               for (int k = 0; k < 3; k++) tsum[k][a] = 0;
            end
            REQ_TRI: begin
               b = int'(r.cb);
               c = int'(r.cc);
               for (int k = 0; k < 3; k++) begin
                  e1[k] = dlt(k, b, a);
                  e2[k] = dlt(k, c, a);
               end
               s1 = dlt(3, b, a);
               t1 = dlt(4, b, a);
               s2 = dlt(3, c, a);
               t2 = dlt(4, c, a);
               det = s1 * t2 - s2 * t1;
               if (det == 0) begin
                  e.degen = 1;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     tv = quot16(t2 * e1[k] - t1 * e2[k], det);
                     tsum[k][a] = clip(tsum[k][a] + tv, -LIM48 - 1, LIM48);
                     tsum[k][b] = clip(tsum[k][b] + tv, -LIM48 - 1, LIM48);
                     tsum[k][c] = clip(tsum[k][c] + tv, -LIM48 - 1, LIM48);
                  end
               end
            end
            REQ_READ: begin
               orthonormal_tangent(a, o);
               for (int k = 0; k < 3; k++) e.t[k] = o[k][31:0];
            end
            default: begin
            end
         endcase
         pending = {pending, e};
      endfunction

      function void check_result(tangent_rsp_type got);
         tangent_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat, echo_index %0d", got.idx);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.idx !== e.idx) begin
            $error("echo_index: expected %0d, actual %0d", e.idx, got.idx);
            errors++;
         end
         for (int k = 0; k < 3; k++) begin
            if (got.t[k] !== e.t[k]) begin
               $error("tangent_%s: expected %0d, actual %0d", k == 0 ? "x" : k == 1 ? "y" : "z",
                      $signed(e.t[k]), $signed(got.t[k]));
               errors++;
            end
         end
         if (got.degen !== e.degen) begin
            $error("degenerate: expected %0b, actual %0b", e.degen, got.degen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = REQ_NOP;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   tangent_scoreboard_type sb = new();
   bit quiet = 0;
   bit loaded[DEPTH];
   int loaded_list[$];
   int stall_left = 0;
   int idle_cycles = 0;

   mesh_tangent_accumulate_orthonormalize_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 8) - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      tangent_rsp_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.idx = rsp_tdata[9:0];
            got.t[0] = rsp_tdata[41:10];
            got.t[1] = rsp_tdata[73:42];
            got.t[2] = rsp_tdata[105:74];
            got.degen = rsp_tuser[0];
            sb.check_result(got);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("mesh_tangent_accumulate_orthonormalize_top test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send(mesh_req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= r.kind;
      req_tdata <= {2'b00, r.cc, r.cb, r.f[7], r.f[6], r.f[5], r.f[4], r.f[3], r.f[2], r.f[1],
                    r.f[0], r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      if (r.kind == REQ_LOAD && !loaded[r.idx]) begin
         loaded[r.idx] = 1;
         loaded_list = {loaded_list, int'(r.idx)};
      end
   endtask

   function automatic mesh_req_type noise_req(logic [1:0] kind);
      mesh_req_type r;
      r.kind = kind;
      r.idx = 10'($urandom_range(0, DEPTH - 1));
      for (int i = 0; i < 8; i++) r.f[i] = $urandom;
      r.cb = 10'($urandom_range(0, DEPTH - 1));
      r.cc = 10'($urandom_range(0, DEPTH - 1));
      return r;
   endfunction

   function automatic logic [31:0] coord();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h80000) - 32'h40000;
      return $urandom;
   endfunction

   task automatic load(int idx, logic [31:0] px, py, pz, u, v, nx, ny, nz);
      mesh_req_type r;
      r = noise_req(REQ_LOAD);
      r.idx = 10'(idx);
      r.f = '{px, py, pz, u, v, nx, ny, nz};
      send(r);
   endtask

   task automatic send_triangle(int a, int b, int c);
      mesh_req_type r;
      r = noise_req(REQ_TRI);
      r.idx = 10'(a);
      r.cb = 10'(b);
      r.cc = 10'(c);
      send(r);
   endtask

   task automatic read_tangent(int a);
      mesh_req_type r;
      r = noise_req(REQ_READ);
      r.idx = 10'(a);
      send(r);
   endtask

   function automatic int pick();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   initial begin
      mesh_req_type r;
      int sel;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      load(0, 0, 0, 0, 0, 0, 0, 0, 32'h10000);
      load(1, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
      load(2, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000);
      read_tangent(1);
      send_triangle(0, 1, 2);
      read_tangent(0);
      load(3, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000);
      send_triangle(0, 3, 2);
      read_tangent(3);
      send_triangle(0, 0, 1);
      load(1023, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
           32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      load(1022, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
           32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      load(1021, 32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF, 0, 0, 0);
      send_triangle(1023, 1022, 1021);
      send_triangle(1021, 1023, 1022);
      read_tangent(1023);
      read_tangent(1022);
      read_tangent(1021);
      send(noise_req(REQ_NOP));
      r = noise_req(REQ_NOP);
      r.idx = 10'd1023;
      send(r);

      for (int n = 0; n < 550; n++) begin
         quiet = n > 470;
         if (n == 300) begin
            req_tvalid <= 0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if (sel < 22 || loaded_list.size() < 3) begin
            load($urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, 23),
                 coord(), coord(), coord(), coord(), coord(),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h20000) - 32'h10000,
                 $urandom_range(0, 32'h20000) - 32'h10000,
                 $urandom_range(0, 32'h20000) - 32'h10000);
         end else if (sel < 70) begin
            send_triangle(pick(), pick(), pick());
         end else if (sel < 95) begin
            read_tangent(pick());
         end else begin
            send(noise_req(REQ_NOP));
         end
      end
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("mesh_tangent_accumulate_orthonormalize_top test passed");
      end else begin
         $display("mesh_tangent_accumulate_orthonormalize_top test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mta_pkg.sv
src/mesh_tangent_accumulate_orthonormalize_top.sv
test/tb_mesh_tangent_accumulate_orthonormalize_top.sv
